### rtl/tdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared constants, payload types and register codes of the triple dipole
// right-hand side evaluator.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int FRAC_BITS = 24;
  localparam int TRIG_ITER = 24;

  // widest angle fed to a sine/cosine unit (pair sums)
  localparam int ANG_W     = 33;
  // angle scaled to Q30
  localparam int RED_W     = ANG_W + 30 - FRAC_BITS;
  // compare/subtract steps of the modulo 2*pi reduction
  localparam int RED_STEPS = RED_W - 33;
  localparam int RES_W     = 35;
  localparam int XY_W      = 34;
  localparam int SC_LAT    = RED_STEPS + TRIG_ITER + 3;

  localparam logic signed [RES_W-1:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [RES_W-1:0] TWO_PI_Q30  = 35'sd6746518852;
  localparam logic signed [RES_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [XY_W-1:0]  CORDIC_K_Q30 = 34'sd652032874;
  localparam logic signed [25:0] INV_36R3_Q30 = 26'sd17220143;
  localparam logic signed [27:0] TWELFTH_Q30  = 28'sd89478485;

  localparam logic signed [31:0] MOMENT_ONE = 32'sd1 <<< FRAC_BITS;

  // atan(2^-i) in Q30, rounded
  localparam logic [30:0] ATAN_Q30 [31] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,
    31'd64,        31'd32,        31'd16,        31'd8,
    31'd4,         31'd2,         31'd1
  };

  localparam logic [1:0] CFG_MOMENT_A = 2'd0;
  localparam logic [1:0] CFG_MOMENT_B = 2'd1;
  localparam logic [1:0] CFG_MOMENT_C = 2'd2;
  localparam logic [1:0] CFG_DAMPING  = 2'd3;

  typedef struct packed {
    logic signed [31:0] angle_a;
    logic signed [31:0] angle_b;
    logic signed [31:0] angle_c;
    logic signed [31:0] rate_a;
    logic signed [31:0] rate_b;
    logic signed [31:0] rate_c;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] dangle_a;
    logic signed [31:0] dangle_b;
    logic signed [31:0] dangle_c;
    logic signed [31:0] accel_a;
    logic signed [31:0] accel_b;
    logic signed [31:0] accel_c;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] rate_a;
    logic signed [31:0] rate_b;
    logic signed [31:0] rate_c;
  } rate_t;

  typedef struct packed {
    logic signed [31:0] sa;
    logic signed [31:0] ca;
    logic signed [31:0] sb;
    logic signed [31:0] cb;
    logic signed [31:0] sc;
    logic signed [31:0] cc;
    logic signed [31:0] cab;
    logic signed [31:0] cac;
  } trig_t;

endpackage

### rtl/tdr_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_sincos
// Pipelined sine/cosine: modulo 2*pi reduction by one compare/subtract per
// stage, fold to [-pi/2, pi/2], then one CORDIC rotation per stage. Q30 out.
// ----------------------------------------------------------------------------
module tdr_sincos import tdr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic signed [ANG_W-1:0] ang_i,
  output logic                    vld_o,
  output logic signed [31:0]      sin_o,
  output logic signed [31:0]      cos_o
);

  localparam int SHIFT = 30 - FRAC_BITS;

  logic signed [RED_W-1:0] ang_q30;
  logic [RED_W-1:0]        mag0;

  logic [RED_W-1:0] mag_r [RED_STEPS+1];
  logic             neg_r [RED_STEPS+1];
  logic             rv_r  [RED_STEPS+1];

  assign ang_q30 = RED_W'(ang_i) <<< SHIFT;
  assign mag0    = ang_q30[RED_W-1] ? RED_W'(-ang_q30) : RED_W'(ang_q30);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r[0] <= mag0;
      neg_r[0] <= ang_q30[RED_W-1];
    end
  end

  for (genvar j = 0; j < RED_STEPS; j++) begin : g_red
    localparam int K = RED_STEPS - 1 - j;
    localparam logic [RED_W-1:0] SUB = RED_W'($unsigned(TWO_PI_Q30)) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[j+1] <= 1'b0;
      end else if (en) begin
        rv_r[j+1] <= rv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[j+1] <= (mag_r[j] >= SUB) ? mag_r[j] - SUB : mag_r[j];
        neg_r[j+1] <= neg_r[j];
      end
    end
  end

  // sign restore, wrap to [-pi, pi), fold to [-pi/2, pi/2]
  logic signed [RES_W-1:0] r_m;
  logic signed [RES_W-1:0] r_w;
  logic signed [RES_W-1:0] r_f;
  logic                    f_neg;

  always_comb begin
    r_m = RES_W'(mag_r[RED_STEPS]);
    if (neg_r[RED_STEPS]) begin
      r_m = -r_m;
    end
    r_w = r_m;
    if (r_m >= PI_Q30) begin
      r_w = r_m - TWO_PI_Q30;
    end else if (r_m < -PI_Q30) begin
      r_w = r_m + TWO_PI_Q30;
    end
    r_f   = r_w;
    f_neg = 1'b0;
    if (r_w > HALF_PI_Q30) begin
      r_f   = r_w - PI_Q30;
      f_neg = 1'b1;
    end else if (r_w < -HALF_PI_Q30) begin
      r_f   = r_w + PI_Q30;
      f_neg = 1'b1;
    end
  end

  logic signed [XY_W-1:0]  x_r  [TRIG_ITER+1];
  logic signed [XY_W-1:0]  y_r  [TRIG_ITER+1];
  logic signed [RES_W-1:0] z_r  [TRIG_ITER+1];
  logic                    fn_r [TRIG_ITER+1];
  logic                    cv_r [TRIG_ITER+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= rv_r[RED_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= CORDIC_K_Q30;
      y_r[0]  <= '0;
      z_r[0]  <= r_f;
      fn_r[0] <= f_neg;
    end
  end

  for (genvar i = 0; i < TRIG_ITER; i++) begin : g_cordic
    localparam logic signed [RES_W-1:0] ANG = RES_W'(ATAN_Q30[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ANG;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ANG;
        end
        fn_r[i+1] <= fn_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= cv_r[TRIG_ITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_o <= fn_r[TRIG_ITER] ? 32'(-y_r[TRIG_ITER]) : 32'(y_r[TRIG_ITER]);
      cos_o <= fn_r[TRIG_ITER] ? 32'(-x_r[TRIG_ITER]) : 32'(x_r[TRIG_ITER]);
    end
  end

endmodule

### rtl/tdr_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdr_mix
// Eight-stage product/sum pipeline: trig products, moment weighting,
// scaling by 1/(36*sqrt(3)) and 1/12, moment times sum, damping, saturation.
// ----------------------------------------------------------------------------
module tdr_mix import tdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  trig_t              trig_i,
  input  rate_t              rate_i,
  input  logic signed [31:0] m1,
  input  logic signed [31:0] m2,
  input  logic signed [31:0] m3,
  input  logic [24:0]        damping,
  output logic               vld_o,
  output out_item_t          out_o
);

  localparam logic signed [63:0] HALF_30 = 64'sd1 <<< 29;
  localparam logic signed [65:0] HALF_30W = 66'sd1 <<< 29;
  localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);

  function automatic logic signed [33:0] pq(input logic signed [31:0] u,
                                            input logic signed [31:0] v);
    logic signed [63:0] pr;
    pr = 64'(u) * 64'(v);
    return 34'((pr + HALF_30) >>> 30);
  endfunction

  function automatic logic signed [35:0] mt(input logic signed [31:0] m,
                                            input logic signed [33:0] p);
    logic signed [65:0] pr;
    pr = 66'(m) * 66'(p);
    return 36'((pr + HALF_30W) >>> 30);
  endfunction

  logic [7:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[6:0], vld_i};
    end
  end

  assign vld_o = vld_r[7];

  // stage 1: trig products
  logic signed [33:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r;
  logic signed [31:0] cab_r, cac_r;
  rate_t rt1_r, rt2_r, rt3_r, rt4_r, rt5_r, rt6_r, rt7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r  <= pq(trig_i.cb, trig_i.sa);
      p2_r  <= pq(trig_i.cc, trig_i.sa);
      p3_r  <= pq(trig_i.ca, trig_i.sb);
      p4_r  <= pq(trig_i.ca, trig_i.sc);
      p5_r  <= pq(trig_i.cc, trig_i.sb);
      p6_r  <= pq(trig_i.cb, trig_i.sc);
      cab_r <= trig_i.cab;
      cac_r <= trig_i.cac;
      rt1_r <= rate_i;
    end
  end

  // stage 2: moment weighting
  logic signed [35:0] ta1_r, ta2_r, ta3_r, ta4_r, ta5_r, ta6_r;
  logic signed [35:0] tb1_r, tb2_r, tb3_r, tb4_r, tb5_r;
  logic signed [35:0] tc1_r, tc2_r, tc3_r, tc4_r, tc5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ta1_r <= mt(m2, p1_r);
      ta2_r <= mt(m3, p2_r);
      ta3_r <= mt(m2, p3_r);
      ta4_r <= mt(m3, p4_r);
      ta5_r <= mt(m2, 34'(cab_r));
      ta6_r <= mt(m3, 34'(cac_r));
      tb1_r <= mt(m1, p3_r);
      tb2_r <= mt(m3, p5_r);
      tb3_r <= mt(m1, p1_r);
      tb4_r <= mt(m3, p6_r);
      tb5_r <= mt(m1, 34'(cab_r));
      tc1_r <= mt(m1, p2_r);
      tc2_r <= mt(m2, p5_r);
      tc3_r <= mt(m1, p4_r);
      tc4_r <= mt(m2, p6_r);
      tc5_r <= mt(m1, 34'(cac_r));
      rt2_r <= rt1_r;
    end
  end

  // stage 3: weighted sums
  logic signed [39:0] ua_r, ub_r, uc_r;
  logic signed [39:0] va_r, vb_r, vc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r  <= 40'(ta1_r) * 40'sd5 + 40'(ta2_r) * 40'sd5 + 40'(ta3_r) + 40'(ta4_r);
      ub_r  <= 40'(tb1_r) * 40'sd5 - 40'(tb2_r) * 40'sd4 + 40'(tb3_r)
             - 40'(tb4_r) * 40'sd8;
      uc_r  <= 40'(tc2_r) * 40'sd8 - 40'(tc1_r) - 40'(tc3_r) * 40'sd5
             + 40'(tc4_r) * 40'sd4;
      va_r  <= 40'(ta5_r) - 40'(ta6_r);
      vb_r  <= 40'(tb5_r);
      vc_r  <= 40'(tc5_r);
      rt3_r <= rt2_r;
    end
  end

  // stage 4: scale products
  logic signed [63:0] cua_r, cub_r, cuc_r, cva_r, cvb_r, cvc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cua_r <= 64'(ua_r) * 64'(INV_36R3_Q30);
      cub_r <= 64'(ub_r) * 64'(INV_36R3_Q30);
      cuc_r <= 64'(uc_r) * 64'(INV_36R3_Q30);
      cva_r <= 64'(va_r) * 64'(TWELFTH_Q30);
      cvb_r <= 64'(vb_r) * 64'(TWELFTH_Q30);
      cvc_r <= 64'(vc_r) * 64'(TWELFTH_Q30);
      rt4_r <= rt3_r;
    end
  end

  // stage 5: combine and round
  logic signed [33:0] wa_r, wb_r, wc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wa_r  <= 34'((cua_r + cva_r + HALF_30) >>> 30);
      wb_r  <= 34'((cub_r + cvb_r + HALF_30) >>> 30);
      wc_r  <= 34'((cuc_r + cvc_r + HALF_30) >>> 30);
      rt5_r <= rt4_r;
    end
  end

  // stage 6: moment times sum, damping times rate
  logic signed [63:0] pa_r, pb_r, pc_r, da_r, db_r, dc_r;
  logic signed [25:0] damp_s;

  assign damp_s = $signed({1'b0, damping});

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= 64'(m1) * 64'(wa_r);
      pb_r  <= 64'(m2) * 64'(wb_r);
      pc_r  <= 64'(m3) * 64'(wc_r);
      da_r  <= 64'(damp_s) * 64'(rt5_r.rate_a);
      db_r  <= 64'(damp_s) * 64'(rt5_r.rate_b);
      dc_r  <= 64'(damp_s) * 64'(rt5_r.rate_c);
      rt6_r <= rt5_r;
    end
  end

  // stage 7: round to output format
  logic signed [39:0] fa_r, fb_r, fc_r, ea_r, eb_r, ec_r;

  always_ff @(posedge clk) begin
    if (en) begin
      fa_r  <= 40'((HALF_F - pa_r) >>> FRAC_BITS);
      fb_r  <= 40'((HALF_F - pb_r) >>> FRAC_BITS);
      fc_r  <= 40'((pc_r + HALF_F) >>> FRAC_BITS);
      ea_r  <= 40'((da_r + HALF_F) >>> FRAC_BITS);
      eb_r  <= 40'((db_r + HALF_F) >>> FRAC_BITS);
      ec_r  <= 40'((dc_r + HALF_F) >>> FRAC_BITS);
      rt7_r <= rt6_r;
    end
  end

  // stage 8: subtract damping, saturate
  logic signed [40:0] acc_a, acc_b, acc_c;
  logic signed [31:0] sat_a, sat_b, sat_c;
  logic               ovf_a, ovf_b, ovf_c;

  function automatic logic [32:0] sat32(input logic signed [40:0] v);
    if (v > 41'sd2147483647) begin
      return {1'b1, 32'h7fff_ffff};
    end else if (v < -41'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  always_comb begin
    acc_a = 41'(fa_r) - 41'(ea_r);
    acc_b = 41'(fb_r) - 41'(eb_r);
    acc_c = 41'(fc_r) - 41'(ec_r);
    {ovf_a, sat_a} = sat32(acc_a);
    {ovf_b, sat_b} = sat32(acc_b);
    {ovf_c, sat_c} = sat32(acc_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_o.dangle_a <= rt7_r.rate_a;
      out_o.dangle_b <= rt7_r.rate_b;
      out_o.dangle_c <= rt7_r.rate_c;
      out_o.accel_a  <= sat_a;
      out_o.accel_b  <= sat_b;
      out_o.accel_c  <= sat_c;
      out_o.overflow <= ovf_a | ovf_b | ovf_c;
    end
  end

endmodule

### rtl/triple_dipole_rhs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triple_dipole_rhs
// Right-hand side of three coupled rotating dipoles, one evaluation per item.
//
// Input channel (in_valid / in_stall / in_data): three angles and three rates,
// signed Q8.24. A transfer happens on a rising edge with in_valid high and
// in_stall low. Result channel (out_valid / out_stall / out_data): the rates
// passed through, three saturated accelerations and an overflow flag.
// Config port (cfg_we / cfg_idx / cfg_wdata): moments a, b, c and damping;
// write them only while the pipeline is empty (the block does not enforce it).
// An item passes the angle reduction and CORDIC pipelines, then the product
// pipeline. One item can be taken every cycle while the result is not
// stalled. The whole pipeline advances together; a stalled result
// at the output register holds every stage and raises in_stall.
// Synchronous reset empties the pipeline and loads moments of 1.0 and zero
// damping.
// ----------------------------------------------------------------------------
module triple_dipole_rhs import tdr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_wdata
);

  logic signed [31:0] moment_a_r, moment_b_r, moment_c_r;
  logic [24:0]        damping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moment_a_r <= MOMENT_ONE;
      moment_b_r <= MOMENT_ONE;
      moment_c_r <= MOMENT_ONE;
      damping_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MOMENT_A: moment_a_r <= cfg_wdata;
        CFG_MOMENT_B: moment_b_r <= cfg_wdata;
        CFG_MOMENT_C: moment_c_r <= cfg_wdata;
        CFG_DAMPING:  damping_r  <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  logic adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [ANG_W-1:0] ang_a, ang_b, ang_c, ang_ab, ang_ac;

  assign ang_a  = ANG_W'(in_data.angle_a);
  assign ang_b  = ANG_W'(in_data.angle_b);
  assign ang_c  = ANG_W'(in_data.angle_c);
  assign ang_ab = ang_a + ang_b;
  assign ang_ac = ang_a + ang_c;

  trig_t trig;
  logic  sc_vld;

  tdr_sincos u_sc_a (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(in_valid), .ang_i(ang_a),
    .vld_o(sc_vld), .sin_o(trig.sa), .cos_o(trig.ca)
  );

  tdr_sincos u_sc_b (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(in_valid), .ang_i(ang_b),
    .vld_o(), .sin_o(trig.sb), .cos_o(trig.cb)
  );

  tdr_sincos u_sc_c (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(in_valid), .ang_i(ang_c),
    .vld_o(), .sin_o(trig.sc), .cos_o(trig.cc)
  );

  tdr_sincos u_sc_ab (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(in_valid), .ang_i(ang_ab),
    .vld_o(), .sin_o(), .cos_o(trig.cab)
  );

  tdr_sincos u_sc_ac (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(in_valid), .ang_i(ang_ac),
    .vld_o(), .sin_o(), .cos_o(trig.cac)
  );

  // rates ride alongside the trig pipelines
  rate_t rate_in;
  rate_t rate_dly_r [SC_LAT];

  always_comb begin
    rate_in.rate_a = in_data.rate_a;
    rate_in.rate_b = in_data.rate_b;
    rate_in.rate_c = in_data.rate_c;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rate_dly_r[0] <= rate_in;
      for (int k = 1; k < SC_LAT; k++) begin
        rate_dly_r[k] <= rate_dly_r[k-1];
      end
    end
  end

  tdr_mix u_mix (
    .clk(clk), .rst_n(rst_n), .en(adv), .vld_i(sc_vld), .trig_i(trig),
    .rate_i(rate_dly_r[SC_LAT-1]),
    .m1(moment_a_r), .m2(moment_b_r), .m3(moment_c_r), .damping(damping_r),
    .vld_o(out_valid), .out_o(out_data)
  );

  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.overflow) |->
      (out_data.accel_a == 32'sh7fff_ffff || out_data.accel_a == 32'sh8000_0000 ||
       out_data.accel_b == 32'sh7fff_ffff || out_data.accel_b == 32'sh8000_0000 ||
       out_data.accel_c == 32'sh7fff_ffff || out_data.accel_c == 32'sh8000_0000))
    else $error("overflow flagged without a saturated acceleration");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sc_vld) && $stable(out_valid))
    else $error("pipeline moved while output stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input held off with empty output register");

endmodule
